>>> hdl/btds_pkg.sv
// shared constants, opcodes and interface types for the byte translate filter
`default_nettype none

package btds_pkg;

	// default depth of each expanded set list
	localparam int unsigned SET_DEPTH_DEF = 256;

	// one table entry per byte value
	localparam int unsigned TAB_SIZE = 256;

	// sweep counter wide enough to hold the table size itself
	localparam int unsigned CTR_W = 9;

	// output queue between the lookup pipeline and the receiver
	localparam int unsigned OUT_DEPTH = 4;
	localparam int unsigned OUT_PTR_W = 2;
	localparam int unsigned OUT_CNT_W = 3;

	// request opcodes
	typedef enum logic [2:0] {
		OP_CLEAR   = 3'd0,
		OP_APPEND1 = 3'd1,
		OP_APPEND2 = 3'd2,
		OP_BUILD   = 3'd3,
		OP_DATA    = 3'd4
	} op_t;

	// configuration register indexes
	localparam logic [1:0] CFG_DELETE     = 2'd0;
	localparam logic [1:0] CFG_SQUEEZE    = 2'd1;
	localparam logic [1:0] CFG_COMPLEMENT = 2'd2;

	// translation table entry: membership bit and mapped byte
	typedef struct packed {
		logic       member;
		logic [7:0] map;
	} tab_ent_t;

	// table access commands from the build sequencer
	typedef struct packed {
		logic       tab_we;
		logic [7:0] tab_addr;
		tab_ent_t   tab_wdata;
		logic [7:0] tab_raddr;
		logic       sq_we;
		logic [7:0] sq_addr;
		logic       sq_wdata;
	} tbl_cmd_t;

endpackage

`default_nettype wire

>>> hdl/byte_translate_delete_squeeze.sv
// top level of the byte translate / delete / squeeze filter
//
// Requests arrive on the in channel (operation, byte_value) with valid/ready.
// Clear, append to set1 and append to set2 give no result; unused opcodes
// are taken and ignored. A build request walks the lists and rewrites the
// tables, with an extra complement pass when complement mode is set; in_ready
// stays low until it is done. A build waits until no data byte is left in flight.
// Data bytes stream at one per cycle while no build runs and the output queue
// has room; a kept byte passes the table read register, the result register
// and the output queue before it shows on out_valid/out_byte. The translation
// table and the squeeze map have one read port each and are read once per byte.
// A four-entry output queue decouples the receiver: while it stalls, data
// requests continue until the queue and the pipeline hold four bytes.
// Configuration registers are written through cfg_valid/cfg_ready, always
// ready, and are meant to change only while no request is in progress.
// After reset the lists are empty, both maps read as empty and no byte has
// been emitted; the translation table holds no defined content until a build.
`default_nettype none

module byte_translate_delete_squeeze
	import btds_pkg::*;
#(
	parameter int unsigned SET_DEPTH = SET_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [2:0] operation,
	input  wire logic [7:0] byte_value,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic       cfg_data
);

	localparam int unsigned IDX_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(SET_DEPTH + 1);

	logic             delete_mode_q;
	logic             squeeze_mode_q;
	logic             complement_mode_q;

	logic             is_data;
	logic             is_build;
	logic             acc;
	logic             build_busy;
	logic             credit_ok;
	logic             pipe_empty;

	logic [IDX_W-1:0] l1_addr;
	logic [IDX_W-1:0] l2_addr;
	logic [7:0]       l1_data;
	logic [7:0]       l2_data;
	logic [CNT_W-1:0] n1;
	logic [CNT_W-1:0] n2;
	tab_ent_t         tab_rdata;
	tbl_cmd_t         cmd;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delete_mode_q     <= 1'b0;
			squeeze_mode_q    <= 1'b0;
			complement_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DELETE:     delete_mode_q     <= cfg_data;
				CFG_SQUEEZE:    squeeze_mode_q    <= cfg_data;
				CFG_COMPLEMENT: complement_mode_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// request admission
	assign is_data  = (operation == OP_DATA);
	assign is_build = (operation == OP_BUILD);
	assign in_ready = !build_busy && (!is_data || credit_ok) && (!is_build || pipe_empty);
	assign acc      = in_valid && in_ready;

	btds_set_store #(
		.SET_DEPTH (SET_DEPTH)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (acc && (operation == OP_CLEAR)),
		.app1    (acc && (operation == OP_APPEND1)),
		.app2    (acc && (operation == OP_APPEND2)),
		.wr_byte (byte_value),
		.l1_addr (l1_addr),
		.l2_addr (l2_addr),
		.l1_data (l1_data),
		.l2_data (l2_data),
		.n1      (n1),
		.n2      (n2)
	);

	btds_build #(
		.SET_DEPTH (SET_DEPTH)
	) u_build (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (acc && is_build),
		.delete_mode     (delete_mode_q),
		.complement_mode (complement_mode_q),
		.n1              (n1),
		.n2              (n2),
		.l1_addr         (l1_addr),
		.l2_addr         (l2_addr),
		.l1_data         (l1_data),
		.l2_data         (l2_data),
		.tab_rdata       (tab_rdata),
		.cmd             (cmd),
		.busy            (build_busy)
	);

	btds_lookup u_lookup (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_accept  (acc && is_data),
		.data_byte    (byte_value),
		.delete_mode  (delete_mode_q),
		.squeeze_mode (squeeze_mode_q),
		.build_start  (acc && is_build),
		.build_busy   (build_busy),
		.cmd          (cmd),
		.tab_rdata    (tab_rdata),
		.credit_ok    (credit_ok),
		.pipe_empty   (pipe_empty),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte)
	);

endmodule

`default_nettype wire

>>> hdl/btds_set_store.sv
// storage for the expanded set lists and their fill counts
`default_nettype none

module btds_set_store
	import btds_pkg::*;
#(
	parameter int unsigned SET_DEPTH = SET_DEPTH_DEF
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       clear,
	input  wire logic                                       app1,
	input  wire logic                                       app2,
	input  wire logic [7:0]                                 wr_byte,
	input  wire logic [((SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1)-1:0] l1_addr,
	input  wire logic [((SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1)-1:0] l2_addr,
	output logic      [7:0]                                 l1_data,
	output logic      [7:0]                                 l2_data,
	output logic      [$clog2(SET_DEPTH + 1)-1:0]           n1,
	output logic      [$clog2(SET_DEPTH + 1)-1:0]           n2
);

	localparam int unsigned IDX_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(SET_DEPTH + 1);

	logic [7:0]       list1_mem [SET_DEPTH];
	logic [7:0]       list2_mem [SET_DEPTH];
	logic [CNT_W-1:0] n1_q;
	logic [CNT_W-1:0] n2_q;
	logic             wr1;
	logic             wr2;

	// appends past a full list are dropped
	assign wr1 = app1 && (n1_q < CNT_W'(SET_DEPTH));
	assign wr2 = app2 && (n2_q < CNT_W'(SET_DEPTH));

	// fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n1_q <= '0;
			n2_q <= '0;
		end else if (clear) begin
			n1_q <= '0;
			n2_q <= '0;
		end else begin
			if (wr1) begin
				n1_q <= n1_q + 1'b1;
			end
			if (wr2) begin
				n2_q <= n2_q + 1'b1;
			end
		end
	end

	// list memories, one write and one registered read each
	always_ff @(posedge clk) begin
		if (wr1) begin
			list1_mem[n1_q[IDX_W-1:0]] <= wr_byte;
		end
		if (wr2) begin
			list2_mem[n2_q[IDX_W-1:0]] <= wr_byte;
		end
		l1_data <= list1_mem[l1_addr];
		l2_data <= list2_mem[l2_addr];
	end

	assign n1 = n1_q;
	assign n2 = n2_q;

endmodule

`default_nettype wire

>>> hdl/btds_build.sv
// sequencer that sweeps the set lists and rewrites the lookup tables
`default_nettype none

module btds_build
	import btds_pkg::*;
#(
	parameter int unsigned SET_DEPTH = SET_DEPTH_DEF
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       start,
	input  wire logic                                       delete_mode,
	input  wire logic                                       complement_mode,
	input  wire logic [$clog2(SET_DEPTH + 1)-1:0]           n1,
	input  wire logic [$clog2(SET_DEPTH + 1)-1:0]           n2,
	output logic      [((SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1)-1:0] l1_addr,
	output logic      [((SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1)-1:0] l2_addr,
	input  wire logic [7:0]                                 l1_data,
	input  wire logic [7:0]                                 l2_data,
	input  wire tab_ent_t                                   tab_rdata,
	output tbl_cmd_t                                        cmd,
	output logic                                            busy
);

	localparam int unsigned IDX_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(SET_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_SET1,
		ST_COMP,
		ST_SQZ
	} state_t;

	state_t           state_q;
	logic [CTR_W-1:0] ctr_q;
	logic             pend_q;
	logic [7:0]       c_s1_q;
	logic [IDX_W-1:0] j_q;
	logic             cmp_q;
	logic             xlate_q;
	logic             sqlist_q;

	logic [CTR_W-1:0] limit;
	logic             issue;
	logic             cons;
	logic             j_more;
	logic [IDX_W-1:0] j_next;
	logic [CNT_W-1:0] n2_last;
	logic [IDX_W-1:0] l2_clamp;

	// sweep length of the current phase
	always_comb begin
		unique case (state_q)
			ST_SET1: limit = CTR_W'(n1);
			ST_SQZ:  limit = sqlist_q ? CTR_W'(n2) : CTR_W'(TAB_SIZE);
			default: limit = CTR_W'(TAB_SIZE);
		endcase
	end

	assign issue = (state_q != ST_IDLE) && (ctr_q < limit);

	// set2 index for set1 position, last entry repeating
	assign n2_last  = n2 - CNT_W'(1);
	assign l2_clamp = (ctr_q < CTR_W'(n2)) ? ctr_q[IDX_W-1:0] : n2_last[IDX_W-1:0];

	// complement walk: each new member takes the next set2 byte
	assign cons   = xlate_q && !tab_rdata.member;
	assign j_more = CNT_W'(j_q) < n2_last;
	assign j_next = ((state_q == ST_COMP) && pend_q && cons && j_more) ? j_q + 1'b1 : j_q;

	// list read addresses
	always_comb begin
		l1_addr = ctr_q[IDX_W-1:0];
		unique case (state_q)
			ST_SET1: l2_addr = l2_clamp;
			ST_COMP: l2_addr = j_next;
			default: l2_addr = ctr_q[IDX_W-1:0];
		endcase
	end

	// table writes; past the init sweep, issued from the registered read data of the previous cycle
	always_comb begin
		cmd           = '0;
		cmd.tab_raddr = ctr_q[7:0];
		unique case (state_q)
			ST_INIT: begin
				if (issue) begin
					cmd.tab_we            = 1'b1;
					cmd.tab_addr          = ctr_q[7:0];
					cmd.tab_wdata.member  = 1'b0;
					cmd.tab_wdata.map     = ctr_q[7:0];
					cmd.sq_we             = 1'b1;
					cmd.sq_addr           = ctr_q[7:0];
					cmd.sq_wdata          = 1'b0;
				end
			end
			ST_SET1: begin
				if (pend_q) begin
					cmd.tab_we           = 1'b1;
					cmd.tab_addr         = l1_data;
					cmd.tab_wdata.member = 1'b1;
					cmd.tab_wdata.map    = (xlate_q && !cmp_q) ? l2_data : l1_data;
				end
			end
			ST_COMP: begin
				if (pend_q) begin
					cmd.tab_we           = 1'b1;
					cmd.tab_addr         = c_s1_q;
					cmd.tab_wdata.member = !tab_rdata.member;
					cmd.tab_wdata.map    = cons ? l2_data : c_s1_q;
				end
			end
			ST_SQZ: begin
				if (pend_q) begin
					cmd.sq_we    = 1'b1;
					cmd.sq_addr  = sqlist_q ? l2_data : c_s1_q;
					cmd.sq_wdata = sqlist_q ? 1'b1 : tab_rdata.member;
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	// phase sequencing and sweep counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ctr_q    <= '0;
			pend_q   <= 1'b0;
			c_s1_q   <= '0;
			j_q      <= '0;
			cmp_q    <= 1'b0;
			xlate_q  <= 1'b0;
			sqlist_q <= 1'b0;
		end else begin
			pend_q <= issue && (state_q != ST_INIT);
			c_s1_q <= ctr_q[7:0];
			if (state_q == ST_IDLE) begin
				if (start) begin
					state_q  <= ST_INIT;
					ctr_q    <= '0;
					j_q      <= '0;
					cmp_q    <= complement_mode;
					xlate_q  <= !delete_mode && (n2 != '0);
					sqlist_q <= (n2 != '0);
				end
			end else begin
				j_q <= j_next;
				if (issue) begin
					ctr_q <= ctr_q + 1'b1;
				end else if (!pend_q) begin
					ctr_q <= '0;
					unique case (state_q)
						ST_INIT: state_q <= ST_SET1;
						ST_SET1: state_q <= cmp_q ? ST_COMP : ST_SQZ;
						ST_COMP: state_q <= ST_SQZ;
						default: state_q <= ST_IDLE;
					endcase
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/btds_lookup.sv
// lookup tables, per-byte delete / translate / squeeze pipeline and output queue
`default_nettype none

module btds_lookup
	import btds_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       data_accept,
	input  wire logic [7:0] data_byte,
	input  wire logic       delete_mode,
	input  wire logic       squeeze_mode,
	input  wire logic       build_start,
	input  wire logic       build_busy,
	input  wire tbl_cmd_t   cmd,
	output tab_ent_t        tab_rdata,
	output logic            credit_ok,
	output logic            pipe_empty,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte
);

	tab_ent_t             tab_mem [TAB_SIZE];
	logic                 sq_mem  [TAB_SIZE];
	tab_ent_t             tab_rd_q;
	logic                 sq_rd_q;
	logic [7:0]           tab_raddr;

	logic                 v_s1_q;
	logic                 v_s2_q;
	logic [7:0]           res_s2;
	logic                 built_q;
	logic                 last_valid_q;
	logic [7:0]           last_q;

	logic [7:0]           fifo_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q;
	logic [OUT_PTR_W-1:0] rd_ptr_q;
	logic [OUT_CNT_W-1:0] count_q;

	logic                 del;
	logic                 drop;
	logic                 push;
	logic                 pop;

	// the sequencer owns the table read port while a build runs
	assign tab_raddr = build_busy ? cmd.tab_raddr : data_byte;

	// translation table: written by the build, read per data byte
	always_ff @(posedge clk) begin
		if (cmd.tab_we) begin
			tab_mem[cmd.tab_addr] <= cmd.tab_wdata;
		end
		tab_rd_q <= tab_mem[tab_raddr];
	end

	// squeeze map, read at the translated byte
	always_ff @(posedge clk) begin
		if (cmd.sq_we) begin
			sq_mem[cmd.sq_addr] <= cmd.sq_wdata;
		end
		sq_rd_q <= sq_mem[tab_rd_q.map];
	end

	assign tab_rdata = tab_rd_q;

	// both maps read as empty until the first build
	assign del  = delete_mode && built_q && tab_rd_q.member;
	assign drop = squeeze_mode && built_q && sq_rd_q && last_valid_q && (res_s2 == last_q);
	assign push = v_s2_q && !drop;
	assign pop  = out_valid && out_ready;

	// pipeline valids, build status and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q       <= 1'b0;
			v_s2_q       <= 1'b0;
			built_q      <= 1'b0;
			last_valid_q <= 1'b0;
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			count_q      <= '0;
		end else begin
			v_s1_q <= data_accept;
			v_s2_q <= v_s1_q && !del;
			if (build_start) begin
				built_q      <= 1'b1;
				last_valid_q <= 1'b0;
			end else if (push) begin
				last_valid_q <= 1'b1;
			end
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
		end
	end

	// payload: translated byte, last output and queue entries
	always_ff @(posedge clk) begin
		res_s2 <= tab_rd_q.map;
		if (push) begin
			last_q           <= res_s2;
			fifo_q[wr_ptr_q] <= res_s2;
		end
	end

	// room is reserved for every byte still in the pipeline
	assign credit_ok  = (count_q + OUT_CNT_W'(v_s1_q) + OUT_CNT_W'(v_s2_q))
	                    < OUT_CNT_W'(OUT_DEPTH);
	assign pipe_empty = !v_s1_q && !v_s2_q;
	assign out_valid  = (count_q != '0);
	assign out_byte   = fifo_q[rd_ptr_q];

endmodule

`default_nettype wire

>>> hdl/btds_checker.sv
// port-level checks for the byte translate filter, bound to the top level
`default_nettype none

module btds_checker
	import btds_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic [2:0] operation,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       cfg_valid,
	input wire logic       cfg_ready
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte))
		else $error("output changed while stalled");

	// a build request holds off the next request
	a_build_gate: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (operation == OP_BUILD) |=> !in_ready)
		else $error("request taken right after a build request");

	// an emptied queue refills only from an earlier data request
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && (operation == OP_DATA), 3))
		else $error("output appeared without a matching data request");

	// configuration writes are never stalled
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind byte_translate_delete_squeeze btds_checker u_btds_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.operation (operation),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_byte  (out_byte),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

`default_nettype wire
